/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted list insert engine.
// Needs a clk_i/rst_ni pair in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk_i, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slie_pkg.sv */
// Package for the sorted list insert engine: sizes, op codes, sequencer states.
// No dependencies.
package slie_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = SLOT_W + 1;
  localparam int unsigned LINK_W   = SLOT_W + 1;
  localparam int unsigned DATA_W   = 32;

  // list end marker: all ones in the signed link field
  localparam logic [LINK_W-1:0] END_LINK = {LINK_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_LINK_NEW,
    ST_LINK_PREV,
    ST_RD_OUT
  } state_e;

endpackage

/* hw/rtl/sorted_list_insert_engine.sv */
// Sorted list insert engine: linked list in slot memories, kept in key order.
// Depends on slie_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one op per transaction:
//   clear, insert (key and three payload words) or read of one slot. Output
//   channel (out_valid_o / out_stall_i) returns exactly one result
//   transaction per input transaction, in order.
//   Clear, full-store insert, first insert and the unused op code answer
//   straight from the idle state. A read answers after one memory read.
//   An insert into a non-empty list writes the new slot, then walks the list
//   from the head, one entry per cycle through the registered read port of
//   the key and link memories, then uses the link memory's single write
//   port twice (new slot link, then predecessor link or head).
//   One op is in work at a time; in_stall_o stays high until the sequencer is
//   idle and the output register is free or being emptied.
//   A result waits in the output register while out_stall_i is high; the
//   sequencer holds in its last state until the register frees up.
//   Reset clears count and head and empties the output register. Slot
//   memories are not cleared; only slots written since the last clear are
//   ever walked.
module sorted_list_insert_engine
  import slie_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [slie_pkg::SLOT_W-1:0]   slot_i,
  input  logic signed [slie_pkg::DATA_W-1:0] key_i,
  input  logic signed [slie_pkg::DATA_W-1:0] payload_a_i,
  input  logic signed [slie_pkg::DATA_W-1:0] payload_b_i,
  input  logic signed [slie_pkg::DATA_W-1:0] payload_c_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          insert_code_o,
  output logic [slie_pkg::SLOT_W-1:0]   slot_used_o,
  output logic signed [slie_pkg::DATA_W-1:0] key_out_o,
  output logic signed [slie_pkg::DATA_W-1:0] payload_a_out_o,
  output logic signed [slie_pkg::DATA_W-1:0] payload_b_out_o,
  output logic signed [slie_pkg::DATA_W-1:0] payload_c_out_o,
  output logic signed [slie_pkg::LINK_W-1:0] next_slot_o,
  output logic [slie_pkg::SLOT_W-1:0]   head_slot_o,
  output logic [slie_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                          full_res_o
);

  `include "assert_macros.svh"

  // slot memories: one write port for data, one for links, one shared read port
  logic [DATA_W-1:0] keys_mem  [CAPACITY];
  logic [DATA_W-1:0] pa_mem    [CAPACITY];
  logic [DATA_W-1:0] pb_mem    [CAPACITY];
  logic [DATA_W-1:0] pc_mem    [CAPACITY];
  logic [LINK_W-1:0] links_mem [CAPACITY];

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;     // new slot of an insert, or read slot
  logic [DATA_W-1:0]  key_q, key_d;       // key being inserted
  logic [LINK_W-1:0]  cur_q, cur_d;       // entry under compare in the walk
  logic [LINK_W-1:0]  prev_q, prev_d;     // last entry passed, END_LINK if none

  // read port
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic [DATA_W-1:0]  key_rd_q, pa_rd_q, pb_rd_q, pc_rd_q;
  logic [LINK_W-1:0]  link_rd_q;

  // write ports
  logic               data_we;
  logic               link_we;
  logic [SLOT_W-1:0]  link_waddr;
  logic [LINK_W-1:0]  link_wdata;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic               out_free;
  logic               code_d, full_d;
  logic [SLOT_W-1:0]  slot_used_d;
  logic [DATA_W-1:0]  key_out_d, pa_out_d, pb_out_d, pc_out_d;
  logic [LINK_W-1:0]  next_out_d;
  logic               code_q, full_q;
  logic [SLOT_W-1:0]  slot_used_q, head_out_q;
  logic [COUNT_W-1:0] count_out_q;
  logic [DATA_W-1:0]  key_out_q, pa_out_q, pb_out_q, pc_out_q;
  logic [LINK_W-1:0]  next_out_q;

  logic               in_accept;
  logic               walk_less;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // walk comparator: stored key strictly below the new key
  assign walk_less = $signed(key_rd_q) < $signed(key_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    slot_d      = slot_q;
    key_d       = key_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    rd_en       = 1'b0;
    rd_addr     = slot_q;
    data_we     = 1'b0;
    link_we     = 1'b0;
    link_waddr  = slot_q;
    link_wdata  = cur_q;
    out_load    = 1'b0;
    code_d      = 1'b0;
    full_d      = 1'b0;
    slot_used_d = '0;
    key_out_d   = '0;
    pa_out_d    = '0;
    pb_out_d    = '0;
    pc_out_d    = '0;
    next_out_d  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (op_e'(op_i))
            OP_CLEAR: begin
              count_d  = '0;
              head_d   = '0;
              out_load = 1'b1;
            end
            OP_INSERT: begin
              if (count_q == COUNT_W'(CAPACITY)) begin
                // drop: store full
                full_d   = 1'b1;
                out_load = 1'b1;
              end else begin
                data_we     = 1'b1;
                slot_d      = count_q[SLOT_W-1:0];
                key_d       = key_i;
                slot_used_d = count_q[SLOT_W-1:0];
                if (count_q == '0) begin
                  // first entry: terminate it and answer at once
                  link_we    = 1'b1;
                  link_waddr = '0;
                  link_wdata = END_LINK;
                  count_d    = COUNT_W'(1);
                  code_d     = 1'b1;
                  out_load   = 1'b1;
                end else begin
                  state_d = ST_LOAD;
                end
              end
            end
            OP_READ: begin
              rd_en   = 1'b1;
              rd_addr = slot_i;
              slot_d  = slot_i;
              state_d = ST_RD_OUT;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_LOAD: begin
        // fetch the head entry
        rd_en   = 1'b1;
        rd_addr = head_q;
        cur_d   = {1'b0, head_q};
        prev_d  = END_LINK;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_less) begin
          prev_d = cur_q;
          if (!link_rd_q[LINK_W-1]) begin
            // advance: fetch the successor right away
            cur_d   = link_rd_q;
            rd_en   = 1'b1;
            rd_addr = link_rd_q[SLOT_W-1:0];
          end else begin
            cur_d   = END_LINK;
            state_d = ST_LINK_NEW;
          end
        end else begin
          state_d = ST_LINK_NEW;
        end
      end
      ST_LINK_NEW: begin
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = cur_q;
        state_d    = ST_LINK_PREV;
      end
      ST_LINK_PREV: begin
        if (out_free) begin
          if (!prev_q[LINK_W-1]) begin
            link_we    = 1'b1;
            link_waddr = prev_q[SLOT_W-1:0];
            link_wdata = {1'b0, slot_q};
          end else begin
            head_d = slot_q;
          end
          count_d     = {1'b0, slot_q} + COUNT_W'(1);
          slot_used_d = slot_q;
          out_load    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_RD_OUT: begin
        if (out_free) begin
          slot_used_d = slot_q;
          key_out_d   = key_rd_q;
          pa_out_d    = pa_rd_q;
          pb_out_d    = pb_rd_q;
          pc_out_d    = pc_rd_q;
          next_out_d  = link_rd_q;
          out_load    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    key_q  <= key_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
  end

  // data memories: written once per insert at the new slot
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      keys_mem[count_q[SLOT_W-1:0]] <= key_i;
      pa_mem[count_q[SLOT_W-1:0]]   <= payload_a_i;
      pb_mem[count_q[SLOT_W-1:0]]   <= payload_b_i;
      pc_mem[count_q[SLOT_W-1:0]]   <= payload_c_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      links_mem[link_waddr] <= link_wdata;
    end
  end

  // registered read port, holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q  <= keys_mem[rd_addr];
      pa_rd_q   <= pa_mem[rd_addr];
      pb_rd_q   <= pb_mem[rd_addr];
      pc_rd_q   <= pc_mem[rd_addr];
      link_rd_q <= links_mem[rd_addr];
    end
  end

  // result register; head and count are captured after this op's update
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      code_q      <= code_d;
      full_q      <= full_d;
      slot_used_q <= slot_used_d;
      key_out_q   <= key_out_d;
      pa_out_q    <= pa_out_d;
      pb_out_q    <= pb_out_d;
      pc_out_q    <= pc_out_d;
      next_out_q  <= next_out_d;
      head_out_q  <= head_d;
      count_out_q <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign insert_code_o   = code_q;
  assign full_res_o      = full_q;
  assign slot_used_o     = slot_used_q;
  assign key_out_o       = key_out_q;
  assign payload_a_out_o = pa_out_q;
  assign payload_b_out_o = pb_out_q;
  assign payload_c_out_o = pc_out_q;
  assign next_slot_o     = next_out_q;
  assign head_slot_o     = head_out_q;
  assign entry_count_o   = count_out_q;

  `ASSERT_CLK(a_count_range, count_q <= COUNT_W'(CAPACITY), "entry count above capacity")
  `ASSERT_CLK(a_head_in_list, (count_q == '0) || ({1'b0, head_q} < count_q), "head outside stored slots")
  `ASSERT_CLK(a_walk_cur_valid, (state_q != ST_WALK) || (!cur_q[LINK_W-1] && ({1'b0, cur_q[SLOT_W-1:0]} < count_q)), "walk on a slot outside the list")
  `ASSERT_IMPL(a_insert_done, (state_q == ST_LINK_PREV) && out_free, (state_q == ST_IDLE) && out_valid_q, "insert finished without a result")

endmodule
